FILE: rtl/core/fsa_pkg.sv
// Shared types and constants for the per-flow statistics table.
// Depends on nothing; used by every module under rtl/core.
package fsa_pkg;

    localparam int FLOW_SLOTS = 4096;
    localparam int SLOT_W     = $clog2(FLOW_SLOTS);
    localparam int ALLOC_W    = SLOT_W + 1;
    localparam int PADDR_W    = 3;

    localparam logic [1:0] STATUS_UPDATED = 2'd0;
    localparam logic [1:0] STATUS_REPORT  = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    localparam logic [15:0] REPORT_RESET = 16'd7;
    localparam logic [PADDR_W-1:0] ADDR_REPORT_COUNT = '0;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  protocol_number;
        logic [15:0] packet_length;
        logic [63:0] arrival_time;
        logic [3:0]  flag_bit_count;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] flow_slot;
        logic [15:0] count_now;
        logic [15:0] length_min;
        logic [15:0] length_max;
        logic [63:0] length_total;
        logic [63:0] gap_min;
        logic [63:0] gap_max;
        logic [63:0] gap_total;
        logic [31:0] flag_total;
    } result_t;

    typedef struct packed {
        logic [63:0] address_pair;
        logic [39:0] ports_protocol;
    } flow_key_t;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] len_min;
        logic [15:0] len_max;
        logic [63:0] len_sum;
        logic [63:0] gap_min;
        logic [63:0] gap_max;
        logic [63:0] gap_sum;
        logic [63:0] last_time;
        logic [31:0] flag_sum;
    } flow_rec_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic fresh;
    } rec_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_READ,
        S_UPDATE
    } fsa_state_t;

endpackage

FILE: rtl/core/fsa_key_mem.sv
// Flow key memory: one synchronous read port, one write port, registered read data, combinational match.
// Depends on fsa_pkg.
module fsa_key_mem (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [fsa_pkg::SLOT_W-1:0] rd_addr,
    input  logic                       wr_en,
    input  logic [fsa_pkg::SLOT_W-1:0] wr_addr,
    input  fsa_pkg::flow_key_t         wr_key,
    input  fsa_pkg::flow_key_t         probe,
    output logic                       hit
);

    fsa_pkg::flow_key_t mem [fsa_pkg::FLOW_SLOTS];
    fsa_pkg::flow_key_t rd_key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_key;
        end
        if (rd_en)
        begin
            rd_key_reg <= mem[rd_addr];
        end
    end

    assign hit = (rd_key_reg == probe);

endmodule

FILE: rtl/core/fsa_rec_mem.sv
// Flow record memory with the statistics update on its read data.
// Depends on fsa_pkg.
module fsa_rec_mem (
    input  logic                       clk,
    input  fsa_pkg::rec_ctl_t          ctl,
    input  logic [fsa_pkg::SLOT_W-1:0] addr,
    input  logic [15:0]                len,
    input  logic [63:0]                now,
    input  logic [3:0]                 flags,
    output fsa_pkg::flow_rec_t         upd
);

    fsa_pkg::flow_rec_t mem [fsa_pkg::FLOW_SLOTS];
    fsa_pkg::flow_rec_t rd_rec_reg;
    logic [63:0]        gap;
    logic [15:0]        old_count;
    logic               first;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= upd;
        end
        if (ctl.rd_en)
        begin
            rd_rec_reg <= mem[addr];
        end
    end

    always_comb
    begin
        old_count = ctl.fresh ? 16'd0 : rd_rec_reg.count;
        first     = (old_count == 16'd0);
        gap       = now - rd_rec_reg.last_time;
        upd       = rd_rec_reg;
        if (first)
        begin
            upd.len_min  = len;
            upd.len_max  = len;
            upd.len_sum  = 64'(len);
            upd.gap_min  = '1;
            upd.gap_max  = '0;
            upd.gap_sum  = '0;
            upd.flag_sum = 32'(flags);
        end
        else
        begin
            if (len < rd_rec_reg.len_min)
            begin
                upd.len_min = len;
            end
            if (len > rd_rec_reg.len_max)
            begin
                upd.len_max = len;
            end
            upd.len_sum = rd_rec_reg.len_sum + 64'(len);
            if (gap < rd_rec_reg.gap_min)
            begin
                upd.gap_min = gap;
            end
            if (gap > rd_rec_reg.gap_max)
            begin
                upd.gap_max = gap;
            end
            upd.gap_sum  = rd_rec_reg.gap_sum + gap;
            upd.flag_sum = rd_rec_reg.flag_sum + 32'(flags);
        end
        upd.last_time = now;
        upd.count     = old_count + 16'd1;
    end

endmodule

FILE: rtl/core/flow_stats_accumulator_unit.sv
// Per-flow packet statistics table: control sequencer, config register, result register.
// Depends on fsa_pkg, fsa_key_mem and fsa_rec_mem.
//
//  channel   signals                          transaction
//  item      start, busy, item                start high while busy low
//  result    done, result                     done high for one cycle, no stall
//  config    psel penable pwrite paddr pwdata register write on access phase
//            prdata pready
//
// N is the number of slots allocated so far. While busy, the key scan reads one key
// memory entry per cycle from slot 0 up to the flow's slot, or through all N slots
// when the flow is not found; a new flow then takes slot N, or is dropped with the
// table full. A flow that is not dropped then gets one record read and one write-back.
// The result appears the cycle after write-back or drop; the receiver cannot stall.
// Reset clears the allocation count and the sequencer and sets report_count to 7.
module flow_stats_accumulator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fsa_pkg::item_t              item,
    output logic                        done,
    output fsa_pkg::result_t            result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fsa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    fsa_pkg::fsa_state_t             state_reg, state_next;
    fsa_pkg::item_t                  pkt_reg;
    logic [fsa_pkg::ALLOC_W-1:0]     alloc_reg, alloc_next;
    logic [fsa_pkg::ALLOC_W-1:0]     idx_reg, idx_next;
    logic                            cmp_vld_reg;
    logic [fsa_pkg::SLOT_W-1:0]      cmp_idx_reg;
    logic [fsa_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic                            fresh_reg, fresh_next;
    logic [15:0]                     report_reg;
    logic                            done_reg;
    fsa_pkg::result_t                result_reg;

    logic                            accept;
    logic                            hit;
    logic                            full;
    logic                            key_rd_en;
    logic                            key_wr_en;
    logic                            drop;
    fsa_pkg::rec_ctl_t               rec_ctl;
    fsa_pkg::flow_key_t              probe;
    fsa_pkg::flow_rec_t              upd;

    assign busy   = (state_reg != fsa_pkg::S_IDLE);
    assign accept = start && !busy;
    assign full   = (alloc_reg == fsa_pkg::ALLOC_W'(fsa_pkg::FLOW_SLOTS));
    assign probe  = '{address_pair:   {pkt_reg.source_address, pkt_reg.dest_address},
                      ports_protocol: {pkt_reg.source_port, pkt_reg.dest_port,
                                       pkt_reg.protocol_number}};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fsa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = fsa_pkg::S_SCAN;
                end
            end
            fsa_pkg::S_SCAN:
            begin
                if (cmp_vld_reg && hit)
                begin
                    state_next = fsa_pkg::S_READ;
                end
                else if (!cmp_vld_reg && idx_reg >= alloc_reg)
                begin
                    state_next = fsa_pkg::S_MISS;
                end
            end
            fsa_pkg::S_MISS:
            begin
                state_next = full ? fsa_pkg::S_IDLE : fsa_pkg::S_READ;
            end
            fsa_pkg::S_READ:
            begin
                state_next = fsa_pkg::S_UPDATE;
            end
            fsa_pkg::S_UPDATE:
            begin
                state_next = fsa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fsa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_rd_en     = 1'b0;
        key_wr_en     = 1'b0;
        drop          = 1'b0;
        rec_ctl.rd_en = 1'b0;
        rec_ctl.wr_en = 1'b0;
        rec_ctl.fresh = fresh_reg;
        idx_next      = idx_reg;
        alloc_next    = alloc_reg;
        slot_next     = slot_reg;
        fresh_next    = fresh_reg;
        case (state_reg)
            fsa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    fresh_next = 1'b0;
                end
            end
            fsa_pkg::S_SCAN:
            begin
                key_rd_en = (idx_reg < alloc_reg);
                if (key_rd_en)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (cmp_vld_reg && hit)
                begin
                    slot_next = cmp_idx_reg;
                end
            end
            fsa_pkg::S_MISS:
            begin
                drop      = full;
                key_wr_en = !full;
                if (!full)
                begin
                    slot_next  = alloc_reg[fsa_pkg::SLOT_W-1:0];
                    alloc_next = alloc_reg + 1'b1;
                    fresh_next = 1'b1;
                end
            end
            fsa_pkg::S_READ:
            begin
                rec_ctl.rd_en = 1'b1;
            end
            fsa_pkg::S_UPDATE:
            begin
                rec_ctl.wr_en = 1'b1;
            end
            default:
            begin
                drop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fsa_pkg::S_IDLE;
            alloc_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            report_reg  <= fsa_pkg::REPORT_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            alloc_reg   <= alloc_next;
            cmp_vld_reg <= key_rd_en;
            done_reg    <= drop || rec_ctl.wr_en;
            if (psel && penable && pwrite && paddr == fsa_pkg::ADDR_REPORT_COUNT)
            begin
                report_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pkt_reg <= item;
        end
        idx_reg     <= idx_next;
        slot_reg    <= slot_next;
        fresh_reg   <= fresh_next;
        cmp_idx_reg <= idx_reg[fsa_pkg::SLOT_W-1:0];
        if (drop)
        begin
            result_reg <= {fsa_pkg::STATUS_DROPPED,
                           {($bits(fsa_pkg::result_t) - 2){1'b0}}};
        end
        else if (rec_ctl.wr_en)
        begin
            result_reg.status       <= (upd.count == report_reg) ? fsa_pkg::STATUS_REPORT
                                                                 : fsa_pkg::STATUS_UPDATED;
            result_reg.flow_slot    <= 12'(slot_reg);
            result_reg.count_now    <= upd.count;
            result_reg.length_min   <= upd.len_min;
            result_reg.length_max   <= upd.len_max;
            result_reg.length_total <= upd.len_sum;
            result_reg.gap_min      <= upd.gap_min;
            result_reg.gap_max      <= upd.gap_max;
            result_reg.gap_total    <= upd.gap_sum;
            result_reg.flag_total   <= upd.flag_sum;
        end
    end

    fsa_key_mem u_key_mem (
        .clk     (clk),
        .rd_en   (key_rd_en),
        .rd_addr (idx_reg[fsa_pkg::SLOT_W-1:0]),
        .wr_en   (key_wr_en),
        .wr_addr (alloc_reg[fsa_pkg::SLOT_W-1:0]),
        .wr_key  (probe),
        .probe   (probe),
        .hit     (hit)
    );

    fsa_rec_mem u_rec_mem (
        .clk   (clk),
        .ctl   (rec_ctl),
        .addr  (slot_reg),
        .len   (pkt_reg.packet_length),
        .now   (pkt_reg.arrival_time),
        .flags (pkt_reg.flag_bit_count),
        .upd   (upd)
    );

    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == fsa_pkg::ADDR_REPORT_COUNT) ? {16'd0, report_reg} : 32'd0;

    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg <= fsa_pkg::ALLOC_W'(fsa_pkg::FLOW_SLOTS))
        else $error("allocation count beyond table size");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg != $past(alloc_reg) |-> alloc_reg == $past(alloc_reg) + 1'b1)
        else $error("allocation count moved by more than one");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(state_reg) == fsa_pkg::S_UPDATE
                        || $past(state_reg) == fsa_pkg::S_MISS)
        else $error("result strobe without write-back or drop");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == fsa_pkg::STATUS_DROPPED
            |-> alloc_reg == fsa_pkg::ALLOC_W'(fsa_pkg::FLOW_SLOTS))
        else $error("drop reported with free slots");

endmodule

FILE: dv/flow_stats_accumulator_unit_tb.sv
// Testbench for flow_stats_accumulator_unit: directed and random packets, predicted
// flow statistics checked result by result. Depends on fsa_pkg and the RTL top level.
module flow_stats_accumulator_unit_tb;

    typedef enum logic [1:0] {J_PKT, J_CFG, J_DRAIN} job_kind_t;
    typedef struct {
        job_kind_t        kind;
        fsa_pkg::item_t   pkt;
        logic [15:0]      value;
        bit               quiet;
    } job_t;

    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    fsa_pkg::item_t   item;
    logic        done;
    fsa_pkg::result_t result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [fsa_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    job_t               job_q[$];
    fsa_pkg::result_t   expected_q[$];
    int                 slot_of[fsa_pkg::flow_key_t];
    fsa_pkg::flow_rec_t recs[fsa_pkg::FLOW_SLOTS];
    int          alloc_count;
    logic [15:0] report_value;
    logic        took;
    int          gap_left;
    int          settle;
    int          apb_phase;
    int          mismatches;
    int          stall_cycles;
    fsa_pkg::flow_key_t pool[$];

    flow_stats_accumulator_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic fsa_pkg::result_t predict_flow_stats(fsa_pkg::item_t p);
        fsa_pkg::flow_key_t k;
        int                 s;
        fsa_pkg::result_t   r;
        logic [63:0]        g;
        k.address_pair   = {p.source_address, p.dest_address};
        k.ports_protocol = {p.source_port, p.dest_port, p.protocol_number};
        r = '0;
        if (slot_of.exists(k))
            s = slot_of[k];
        else if (alloc_count >= fsa_pkg::FLOW_SLOTS)
        begin
            r.status = fsa_pkg::STATUS_DROPPED;
            return r;
        end
        else
        begin
            s = alloc_count;
            alloc_count++;
            slot_of[k] = s;
            recs[s] = '0;
        end
        if (recs[s].count == 16'd0)
        begin
            recs[s].len_min  = p.packet_length;
            recs[s].len_max  = p.packet_length;
            recs[s].len_sum  = {48'd0, p.packet_length};
            recs[s].gap_min  = '1;
            recs[s].gap_max  = '0;
            recs[s].gap_sum  = '0;
            recs[s].flag_sum = {28'd0, p.flag_bit_count};
        end
        else
        begin
            g = p.arrival_time - recs[s].last_time;
            if (p.packet_length < recs[s].len_min) recs[s].len_min = p.packet_length;
            if (p.packet_length > recs[s].len_max) recs[s].len_max = p.packet_length;
            recs[s].len_sum  = recs[s].len_sum + {48'd0, p.packet_length};
            if (g < recs[s].gap_min) recs[s].gap_min = g;
            if (g > recs[s].gap_max) recs[s].gap_max = g;
            recs[s].gap_sum  = recs[s].gap_sum + g;
            recs[s].flag_sum = recs[s].flag_sum + {28'd0, p.flag_bit_count};
        end
        recs[s].last_time = p.arrival_time;
        recs[s].count     = recs[s].count + 16'd1;
        r.status       = (recs[s].count == report_value) ? fsa_pkg::STATUS_REPORT
                                                         : fsa_pkg::STATUS_UPDATED;
        r.flow_slot    = s[11:0];
        r.count_now    = recs[s].count;
        r.length_min   = recs[s].len_min;
        r.length_max   = recs[s].len_max;
        r.length_total = recs[s].len_sum;
        r.gap_min      = recs[s].gap_min;
        r.gap_max      = recs[s].gap_max;
        r.gap_total    = recs[s].gap_sum;
        r.flag_total   = recs[s].flag_sum;
        return r;
    endfunction

    function automatic fsa_pkg::flow_key_t random_key();
        fsa_pkg::flow_key_t k;
        k.address_pair   = {$urandom, $urandom};
        k.ports_protocol = {8'($urandom), $urandom};
        return k;
    endfunction

    task automatic add_packet(fsa_pkg::flow_key_t k, logic [15:0] len, logic [63:0] t,
                              logic [3:0] flags, bit quiet);
        job_t j;
        j.kind  = J_PKT;
        j.value = '0;
        j.quiet = quiet;
        {j.pkt.source_address, j.pkt.dest_address} = k.address_pair;
        {j.pkt.source_port, j.pkt.dest_port, j.pkt.protocol_number} = k.ports_protocol;
        j.pkt.packet_length  = len;
        j.pkt.arrival_time   = t;
        j.pkt.flag_bit_count = flags;
        job_q.push_back(j);
    endtask

    task automatic add_config(logic [15:0] value);
        job_t j;
        j.kind  = J_DRAIN;
        j.pkt   = '0;
        j.value = '0;
        j.quiet = 1'b0;
        job_q.push_back(j);
        j.kind  = J_CFG;
        j.value = value;
        job_q.push_back(j);
    endtask

    task automatic add_random(fsa_pkg::flow_key_t k, bit quiet);
        add_packet(k, 16'($urandom), {$urandom, $urandom}, 4'($urandom), quiet);
    endtask

    // driver
    always @(negedge clk)
    begin : driver
        logic nstart;
        job_t j;
        nstart = start;
        if (rst_n)
        begin
            if (start && took)
                nstart = 1'b0;
            if (apb_phase == 1)
            begin
                penable   <= 1'b1;
                apb_phase = 2;
            end
            else if (apb_phase == 2)
            begin
                psel      <= 1'b0;
                penable   <= 1'b0;
                pwrite    <= 1'b0;
                apb_phase = 0;
            end
            else if (!nstart)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (job_q.size() > 0)
                begin
                    j = job_q[0];
                    case (j.kind)
                        J_PKT:
                        begin
                            item   <= j.pkt;
                            nstart = 1'b1;
                            void'(job_q.pop_front());
                            if (!j.quiet && $urandom_range(0, 3) == 0)
                                gap_left = $urandom_range(1, 10);
                        end
                        J_DRAIN:
                        begin
                            if (expected_q.size() == 0 && !took)
                                settle++;
                            else
                                settle = 0;
                            if (settle >= 30)
                            begin
                                settle = 0;
                                void'(job_q.pop_front());
                            end
                        end
                        default:
                        begin
                            psel      <= 1'b1;
                            pwrite    <= 1'b1;
                            paddr     <= fsa_pkg::ADDR_REPORT_COUNT;
                            pwdata    <= {16'd0, j.value};
                            apb_phase = 1;
                            void'(job_q.pop_front());
                        end
                    endcase
                end
            end
        end
        start <= nstart;
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got,
                               inout bit bad);
        if (want !== got)
        begin
            if (!bad && mismatches < 10)
                $display("mismatch %s: expected %h got %h", name, want, got);
            bad = 1'b1;
        end
    endtask

    // monitor and predictor
    always @(posedge clk)
    begin : monitor
        fsa_pkg::result_t want;
        bit               bad;
        if (rst_n)
        begin
            took <= start && !busy;
            if (start && !busy)
                expected_q.push_back(predict_flow_stats(item));
            if (psel && penable && pwrite && pready && paddr == fsa_pkg::ADDR_REPORT_COUNT)
                report_value = pwdata[15:0];
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected transaction: %p", result);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad  = 1'b0;
                    check_field("status", want.status, result.status, bad);
                    check_field("flow_slot", want.flow_slot, result.flow_slot, bad);
                    check_field("count_now", want.count_now, result.count_now, bad);
                    check_field("length_min", want.length_min, result.length_min, bad);
                    check_field("length_max", want.length_max, result.length_max, bad);
                    check_field("length_total", want.length_total, result.length_total, bad);
                    check_field("gap_min", want.gap_min, result.gap_min, bad);
                    check_field("gap_max", want.gap_max, result.gap_max, bad);
                    check_field("gap_total", want.gap_total, result.gap_total, bad);
                    check_field("flag_total", want.flag_total, result.flag_total, bad);
                    if (bad)
                        mismatches++;
                end
            end
            if ((start && !busy) || done || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG)
            begin
                $display("watchdog expired");
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        fsa_pkg::flow_key_t k;
        fsa_pkg::flow_key_t a;
        fsa_pkg::flow_key_t b;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        took = 1'b0;
        gap_left = 0;
        settle = 0;
        apb_phase = 0;
        mismatches = 0;
        stall_cycles = 0;
        alloc_count = 0;
        report_value = fsa_pkg::REPORT_RESET;

        // directed: extreme keys, lengths, times and flag counts; report at reset value
        a = '0;
        b = '1;
        add_packet(a, 16'd0, 64'd0, 4'd0, 1'b0);
        add_packet(b, 16'hFFFF, '1, 4'd15, 1'b0);
        add_packet(a, 16'hFFFF, '1, 4'd15, 1'b0);
        add_packet(a, 16'd0, 64'd0, 4'd8, 1'b0);
        add_packet(b, 16'd1, 64'd5, 4'd0, 1'b0);
        add_packet(a, 16'd100, 64'd0, 4'd1, 1'b0);
        for (int i = 0; i < 3; i++)
            add_packet(a, 16'(i * 7), 64'd10 + i, 4'd2, 1'b0);
        for (int i = 0; i < 4; i++)
            add_random(random_key(), 1'b0);

        add_config(16'd1);
        add_packet(a, 16'd5, 64'd50, 4'd3, 1'b0);
        k = random_key();
        add_packet(k, 16'd9, 64'd1, 4'd4, 1'b0);
        add_packet(k, 16'd9, 64'd0, 4'd4, 1'b0);

        // report value zero: no report without a count wrap
        add_config(16'd0);
        add_random(k, 1'b0);
        add_random(k, 1'b0);
        add_random(k, 1'b0);

        // random phases, mostly revisiting a small pool of flows; last phase without idling
        for (int i = 0; i < 40; i++)
            pool.push_back(random_key());
        for (int ph = 0; ph < 6; ph++)
        begin
            add_config(16'($urandom_range(1, 12)));
            for (int i = 0; i < 225; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_random(random_key(), ph == 5);
                else
                    add_random(pool[$urandom_range(0, pool.size() - 1)], ph == 5);
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (job_q.size() == 0 && !start && expected_q.size() == 0);
        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
